>>> src/cbm_pkg.sv
// Shared constants and types for the combined-waveform bit model.
package cbm_pkg;

  // Field and register widths.
  localparam int unsigned PHASE_W    = 12;
  localparam int unsigned PHASE_PADW = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;

  // Default DAC resolution.
  localparam int unsigned DAC_BITS_DEF = 12;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_GAIN     = 8'd0,
    REG_DECAY_RATIO  = 8'd1,
    REG_SWITCH_LEVEL = 8'd2
  } cfg_reg_e;

  // Register reset values.
  localparam logic [CFG_W-1:0] BIT_GAIN_RST     = 16'd205;
  localparam logic [CFG_W-1:0] DECAY_RATIO_RST  = 16'd27307;
  localparam logic [CFG_W-1:0] SWITCH_LEVEL_RST = 16'd164;

  // Weight width: bit_gain shifted left by eight, unsigned Q8.16.
  localparam int unsigned WEIGHT_W = CFG_W + 8;

  // Output scale, 15.12 as 1512 / 100.
  localparam int unsigned SCALE_W   = 11;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 11'd1512;

endpackage

>>> src/combined_waveform_bit_model.sv
// Top level of the combined-waveform bit model: weight sequencer and six-stage datapath.

// The block takes one 12-bit phase index per cycle on the slave stream while it is
// neither held by back-pressure nor rebuilding weights, and returns one 16-bit level
// per item on the master stream. Stages: input register, partial sums of four signed
// weights per output bit, full sum per bit, threshold compare, scale by 1512, and a
// reciprocal multiply for the division by 100. Every stage holds its item while the
// stage after it is full and cannot load, so a stalled output loses nothing and
// bubbles are squeezed out. The neighbor weights live in registers filled by a
// sequencer that shares one 24x16 multiplier and computes one weight per cycle:
// after reset and after each write of bit_gain or decay_ratio the input stalls
// while the weights are rebuilt. Configuration writes are always taken; register
// indexes beyond switch_level are ignored.
module combined_waveform_bit_model #(
  parameter int unsigned DAC_BITS = cbm_pkg::DAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cbm_pkg::CFG_W-1:0]         cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cbm_pkg::PHASE_PADW-1:0]    s_axis_tdata,  // [11:0] phase_index, zero pad
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cbm_pkg::LEVEL_W-1:0]       m_axis_tdata   // [15:0] wave_level
);

  localparam int unsigned WW  = cbm_pkg::WEIGHT_W;
  localparam int unsigned CW  = $clog2(DAC_BITS);
  localparam int unsigned NG  = (DAC_BITS + 3) / 4;
  localparam int unsigned PW  = WW + 3;
  localparam int unsigned SW  = WW + 1 + $clog2(DAC_BITS);
  localparam int unsigned THW = cbm_pkg::CFG_W + 9;
  localparam int unsigned XW  = DAC_BITS + cbm_pkg::SCALE_W;
  localparam int unsigned MW  = XW + 1;
  localparam int unsigned QW  = XW - 6;
  localparam int unsigned DIV_SH = XW + 7;
  localparam logic [63:0] DIV_M_FULL = ((64'd1 << DIV_SH) + 64'd99) / 64'd100;
  localparam logic [MW-1:0] DIV_M = DIV_M_FULL[MW-1:0];
  localparam int unsigned NS  = 6;
  localparam int unsigned IW  = (DAC_BITS < cbm_pkg::PHASE_W) ? DAC_BITS : cbm_pkg::PHASE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [cbm_pkg::CFG_W-1:0] gain_q, decay_q, switch_q;
  logic                      cfg_fire, wt_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign wt_restart  = cfg_fire && (cfg_index_i == cbm_pkg::REG_BIT_GAIN ||
                                    cfg_index_i == cbm_pkg::REG_DECAY_RATIO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= cbm_pkg::BIT_GAIN_RST;
      decay_q  <= cbm_pkg::DECAY_RATIO_RST;
      switch_q <= cbm_pkg::SWITCH_LEVEL_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        cbm_pkg::REG_BIT_GAIN:     gain_q   <= cfg_data_i;
        cbm_pkg::REG_DECAY_RATIO:  decay_q  <= cfg_data_i;
        cbm_pkg::REG_SWITCH_LEVEL: switch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Weight sequencer: w[d] = (w[d-1] * decay) >> 16, one distance per cycle.
  logic [WW-1:0]    w0;
  logic [WW-1:0]    w_q [1:DAC_BITS-1];
  logic [WW-1:0]    acc_q, mul_a, w_next;
  logic [WW+15:0]   w_prod;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [WW-1:0]    wt [DAC_BITS];

  assign w0     = {gain_q, 8'b0};
  assign mul_a  = (cnt_q == CW'(1)) ? w0 : acc_q;
  assign w_prod = mul_a * decay_q;
  assign w_next = w_prod[WW+15:16];

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (wt_restart) begin
      cnt_d  = CW'(1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CW'(DAC_BITS - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CW'(1);
      busy_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !wt_restart) begin
      w_q[cnt_q] <= w_next;
      acc_q      <= w_next;
    end
  end

  always_comb begin
    wt[0] = w0;
    for (int d = 1; d < DAC_BITS; d++) begin
      wt[d] = w_q[d];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor loads.
  logic [NS-1:0] vld_q;
  logic [NS:0]   adv;

  assign adv[NS] = m_axis_tready;
  for (genvar s = 0; s < NS; s++) begin : g_adv
    assign adv[s] = !vld_q[s] || adv[s+1];
  end

  assign s_axis_tready = adv[0] && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid && !busy_q;
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Stage 0: input bits; positions above the phase field read as zero.
  logic [DAC_BITS-1:0] bits_q, bits_d;

  always_comb begin
    bits_d = '0;
    bits_d[IW-1:0] = s_axis_tdata[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) bits_q <= bits_d;
  end

  // Stage 1: signed partial sums over groups of four input positions.
  logic signed [PW-1:0] part_q [DAC_BITS][NG];
  logic signed [PW-1:0] part_d [DAC_BITS][NG];

  always_comb begin
    int k;
    int d;
    logic signed [PW-1:0] term;
    for (int j = 0; j < DAC_BITS; j++) begin
      for (int g = 0; g < NG; g++) begin
        part_d[j][g] = '0;
        for (int i = 0; i < 4; i++) begin
          k = 4 * g + i;
          if (k < DAC_BITS) begin
            d = (k > j) ? (k - j) : (j - k);
            term = $signed({3'b000, wt[d]});
            part_d[j][g] = bits_q[k] ? (part_d[j][g] + term) : (part_d[j][g] - term);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) part_q <= part_d;
  end

  // Stage 2: full push at each output position.
  logic signed [SW-1:0] sum_q [DAC_BITS];
  logic signed [SW-1:0] sum_d [DAC_BITS];

  always_comb begin
    for (int j = 0; j < DAC_BITS; j++) begin
      sum_d[j] = '0;
      for (int g = 0; g < NG; g++) begin
        sum_d[j] = sum_d[j] + SW'(part_q[j][g]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) sum_q <= sum_d;
  end

  // Stage 3: threshold compare against switch_level * 512.
  logic signed [THW-1:0] thr;
  logic signed [SW-1:0]  thr_ext;
  logic [DAC_BITS-1:0]   lvl_q, lvl_d;

  assign thr     = $signed({switch_q, 9'b0});
  assign thr_ext = SW'(thr);

  always_comb begin
    for (int j = 0; j < DAC_BITS; j++) begin
      lvl_d[j] = (sum_q[j] >= thr_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) lvl_q <= lvl_d;
  end

  // Stage 4: scale by 1512.
  logic [XW-1:0] x_q, x_d;

  assign x_d = XW'(lvl_q) * XW'(cbm_pkg::SCALE_MUL);

  always_ff @(posedge clk_i) begin
    if (adv[4]) x_q <= x_d;
  end

  // Stage 5: floor division by 100 through a rounded-up reciprocal.
  logic [XW+MW-1:0]             div_prod;
  logic [QW-1:0]                quo;
  logic [QW+cbm_pkg::LEVEL_W-1:0] quo_ext;
  logic [cbm_pkg::LEVEL_W-1:0]  out_q;

  assign div_prod = x_q * DIV_M;
  assign quo      = div_prod[DIV_SH +: QW];
  assign quo_ext  = {{cbm_pkg::LEVEL_W{1'b0}}, quo};

  always_ff @(posedge clk_i) begin
    if (adv[5]) out_q <= quo_ext[cbm_pkg::LEVEL_W-1:0];
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready)
    else $error("input accepted while weights are rebuilt");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transfer did not reach the input stage");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0 && cnt_q <= CW'(DAC_BITS - 1)))
    else $error("weight counter out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wt_restart |=> (busy_q && cnt_q == CW'(1)))
    else $error("weight rebuild did not restart after a register write");

endmodule

>>> tb/tb_combined_waveform_bit_model.sv
// Self-checking testbench for the combined-waveform bit model with random stream stalls.
module tb_combined_waveform_bit_model;

  localparam int unsigned DAC_BITS   = cbm_pkg::DAC_BITS_DEF;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned SWEEP_RUNS = 12;
  localparam int unsigned SWEEP_LEN  = 150;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [cbm_pkg::CFG_IDX_W-1:0] REG_IDX_SPARE = 8'd3;
  localparam logic [cbm_pkg::CFG_IDX_W-1:0] REG_IDX_TOP   = 8'hFF;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [cbm_pkg::CFG_W-1:0]      cfg_data_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [cbm_pkg::PHASE_PADW-1:0] s_axis_tdata = '0;  // [11:0] phase_index, zero pad
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [cbm_pkg::LEVEL_W-1:0]    m_axis_tdata;       // [15:0] wave_level

  // Predictor copy of the registers.
  logic        [cbm_pkg::CFG_W-1:0] gain_q   = cbm_pkg::BIT_GAIN_RST;
  logic        [cbm_pkg::CFG_W-1:0] decay_q  = cbm_pkg::DECAY_RATIO_RST;
  logic signed [cbm_pkg::CFG_W-1:0] thresh_q = cbm_pkg::SWITCH_LEVEL_RST;

  logic [cbm_pkg::LEVEL_W-1:0] level_q [$];
  logic [cbm_pkg::LEVEL_W-1:0] level_want;
  int unsigned                 err_count = 0;
  int unsigned                 level_count = 0;
  int unsigned                 phase_count = 0;
  int unsigned                 setting_count = 1;
  int unsigned                 cycle_count = 0;
  bit                          calm = 1'b0;

  combined_waveform_bit_model #(
    .DAC_BITS(DAC_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // Expected level: every input bit pushes each output position up or down with a
  // weight that falls off geometrically with the distance between the two bits.
  function automatic logic [cbm_pkg::LEVEL_W-1:0] wave_level_of(
    input logic [cbm_pkg::PHASE_W-1:0] phase
  );
    longint            wt [DAC_BITS];
    longint            push;
    longint            limit;
    logic [31:0]       bits;
    longint unsigned   vbits;
    int                d;
    bits  = 32'(phase);
    vbits = 0;
    limit = longint'(thresh_q) * 512;
    wt[0] = longint'(gain_q) * 256;
    for (int n = 1; n < DAC_BITS; n++) begin
      wt[n] = (wt[n-1] * longint'(decay_q)) >>> 16;
    end
    for (int j = 0; j < DAC_BITS; j++) begin
      push = 0;
      for (int k = 0; k < DAC_BITS; k++) begin
        d = (k > j) ? k - j : j - k;
        if (bits[k]) push += wt[d];
        else push -= wt[d];
      end
      if (push >= limit) vbits |= longint'(1) << j;
    end
    return cbm_pkg::LEVEL_W'((vbits * 1512) / 100);
  endfunction

  // Result sink: random back-pressure unless the calm stretch is running.
  always @(negedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (level_q.size() == 0) begin
        $error("wave_level: got %0d with no item outstanding", m_axis_tdata);
        err_count++;
      end else begin
        level_want = level_q.pop_front();
        level_count++;
        if (m_axis_tdata !== level_want) begin
          $error("wave_level: expected %0d, actual %0d", level_want, m_axis_tdata);
          err_count++;
        end
      end
    end
  end

  task automatic send_phase(input logic [cbm_pkg::PHASE_W-1:0] phase);
    while (!calm && $urandom_range(99) < 24) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cbm_pkg::PHASE_PADW'(phase);
    do @(posedge clk_i); while (!s_axis_tready);
    level_q.push_back(wave_level_of(phase));
    phase_count++;
  endtask

  // Lower the stream and wait until every level has come back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbm_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      cbm_pkg::REG_BIT_GAIN:     gain_q   = val;
      cbm_pkg::REG_DECAY_RATIO:  decay_q  = val;
      cbm_pkg::REG_SWITCH_LEVEL: thresh_q = val;
      default: ;
    endcase
  endtask

  // Reset register values: all-zero, all-one, each single bit, alternating patterns and 7FF.
  task automatic test_reset_phases();
    send_phase(12'h000);
    send_phase(12'hFFF);
    for (int k = 0; k < cbm_pkg::PHASE_W; k++) begin
      send_phase(cbm_pkg::PHASE_W'(1) << k);
    end
    send_phase(12'hAAA);
    send_phase(12'h555);
    send_phase(12'h7FF);
    send_phase(12'h800);
    settle();
  endtask

  task automatic test_ignored_index();
    write_reg(REG_IDX_SPARE, 16'h1234);
    write_reg(REG_IDX_TOP, 16'hFFFF);
    send_phase(12'h000);
    send_phase(12'hFFF);
    send_phase(12'h0F0);
    send_phase(12'h5A5);
    settle();
  endtask

  // Register settings from the corners first, then random ones, each with a run of phases.
  task automatic test_setting_sweep();
    logic [cbm_pkg::CFG_W-1:0] g, dr, sl;
    logic [cbm_pkg::PHASE_W-1:0] phase;
    for (int run = 0; run < SWEEP_RUNS; run++) begin
      g  = cbm_pkg::CFG_W'($urandom);
      dr = cbm_pkg::CFG_W'($urandom);
      sl = $urandom_range(1) ? cbm_pkg::CFG_W'($urandom)
                             : cbm_pkg::CFG_W'($urandom_range(2047) - 1024);
      case (run)
        0: begin g = '0; sl = '0; end                      // no push at all: v is all ones
        1: begin g = 16'hFFFF; dr = 16'hFFFF; sl = 16'h8000; end
        2: begin dr = '0; end                              // zero decay
        3: begin g = 16'hFFFF; sl = 16'h7FFF; end
        4: begin g = 16'd1; dr = 16'd1; sl = 16'hFFFF; end
        5: begin g = '0; sl = 16'd1; end                   // no push: v is all zeros
        default: ;
      endcase
      write_reg(cbm_pkg::REG_BIT_GAIN, g);
      write_reg(cbm_pkg::REG_DECAY_RATIO, dr);
      write_reg(cbm_pkg::REG_SWITCH_LEVEL, sl);
      setting_count++;
      for (int n = 0; n < SWEEP_LEN; n++) begin
        phase = cbm_pkg::PHASE_W'($urandom);
        if ($urandom_range(3) == 0) begin
          phase = cbm_pkg::PHASE_W'(1) << $urandom_range(cbm_pkg::PHASE_W-1);
          if ($urandom_range(1)) phase = ~phase;
        end
        send_phase(phase);
      end
      settle();
    end
  endtask

  // Back-to-back transfers with neither side ever idling, at the reset weights.
  task automatic test_full_rate();
    write_reg(cbm_pkg::REG_BIT_GAIN, cbm_pkg::BIT_GAIN_RST);
    write_reg(cbm_pkg::REG_DECAY_RATIO, cbm_pkg::DECAY_RATIO_RST);
    write_reg(cbm_pkg::REG_SWITCH_LEVEL, cbm_pkg::SWITCH_LEVEL_RST);
    setting_count++;
    calm = 1'b1;
    for (int n = 0; n < 120; n++) begin
      send_phase(cbm_pkg::PHASE_W'($urandom));
    end
    settle();
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_phases();
    test_ignored_index();
    test_setting_sweep();
    test_full_rate();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d phase values under %0d register settings, checked %0d levels.",
             phase_count, setting_count, level_count);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
